>>> hw/rtl/hrf_pkg.sv
// Package for the HTTP request framer: types, codes, constants and helpers.
`timescale 1ns / 1ps

package hrf_pkg;

    // Field widths
    localparam int HDR_W = 10;
    localparam int LEN_W = 11;
    localparam int HRF_BUFFER_BYTES = 1024;

    localparam logic [LEN_W-1:0] LEN_MAX = 11'd2047;
    localparam logic [3:0]       NAME_LEN = 4'd14;

    // Characters used by the matchers
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_LO_C  = 8'h63;
    localparam logic [7:0] CH_UP_G  = 8'h47;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_UP_T  = 8'h54;
    localparam logic [7:0] CH_UP_P  = 8'h50;
    localparam logic [7:0] CH_UP_O  = 8'h4f;
    localparam logic [7:0] CH_UP_S  = 8'h53;

    // Input transaction kinds
    localparam logic KIND_OPEN = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_WAIT_HEADER = 3'd0,
        ST_WAIT_BODY   = 3'd1,
        ST_DONE_GET    = 3'd2,
        ST_DONE_POST   = 3'd3,
        ST_DONE_BAD    = 3'd4,
        ST_OVERFLOW    = 3'd5,
        ST_CLOSED      = 3'd6
    } t_status;

    // Request phase
    typedef enum logic [2:0] {
        PH_CLOSED      = 3'd0,
        PH_WAIT_HEADER = 3'd1,
        PH_WAIT_BODY   = 3'd2,
        PH_DONE        = 3'd3,
        PH_OVERFLOW    = 3'd4
    } t_phase;

    // Content-length field parser phase
    typedef enum logic [2:0] {
        LF_SEARCH       = 3'd0,
        LF_BEFORE_COLON = 3'd1,
        LF_AFTER_COLON  = 3'd2,
        LF_DIGITS       = 3'd3,
        LF_FINISHED     = 3'd4
    } t_lf_phase;

    // Method prefix tracker
    typedef enum logic [2:0] {
        M_NONE = 3'd0,
        M_G    = 3'd1,
        M_GE   = 3'd2,
        M_GET  = 3'd3,
        M_P    = 3'd4,
        M_PO   = 3'd5,
        M_POS  = 3'd6,
        M_POST = 3'd7
    } t_method;

    // Content-length parser state, passed between core and parser
    typedef struct packed {
        t_lf_phase        lf_phase;
        logic [3:0]       name_match;
        logic [LEN_W-1:0] value;
    } t_len_state;

    // Channel payloads
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]       status;
        logic [HDR_W-1:0] header_length;
        logic [LEN_W-1:0] body_length;
    } t_out;

    // Lower-case "content-length", one character per index
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h63; // c
            4'd1:    ch = 8'h6f; // o
            4'd2:    ch = 8'h6e; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6e; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2d; // -
            4'd8:    ch = 8'h6c; // l
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6e; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> hw/rtl/hrf_len_parse.sv
// Content-length header field parser: next state for one header byte.
`timescale 1ns / 1ps

module hrf_len_parse (
    input  hrf_pkg::t_len_state i_state,
    input  logic [7:0]          i_byte,
    output hrf_pkg::t_len_state o_state
);
    import hrf_pkg::*;

    logic [7:0]  w_lc;
    logic        w_digit;
    logic [3:0]  w_digit_val;
    logic [14:0] w_value_x10;
    logic        w_name_hit;
    logic [3:0]  w_name_inc;

    // Case folding and digit decode
    assign w_lc        = (i_byte >= CH_UP_A && i_byte <= CH_UP_Z) ? (i_byte + 8'h20) : i_byte;
    assign w_digit     = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_digit_val = 4'(i_byte - CH_ZERO);

    // Running value times ten plus the new digit
    assign w_value_x10 = ({4'b0, i_state.value} << 3) + ({4'b0, i_state.value} << 1)
                         + {11'b0, w_digit_val};

    // Name matcher compare
    assign w_name_hit = (i_state.name_match < NAME_LEN)
                        && (w_lc == name_char(i_state.name_match));
    assign w_name_inc = i_state.name_match + 4'd1;

    always_comb begin
        o_state = i_state;
        case (i_state.lf_phase)
            LF_SEARCH: begin
                if (w_name_hit) begin
                    if (w_name_inc == NAME_LEN) begin
                        o_state.name_match = 4'd0;
                        o_state.lf_phase   = LF_BEFORE_COLON;
                    end else begin
                        o_state.name_match = w_name_inc;
                    end
                end else begin
                    o_state.name_match = (w_lc == CH_LO_C) ? 4'd1 : 4'd0;
                end
            end
            LF_BEFORE_COLON: begin
                if (i_byte == CH_COLON) begin
                    o_state.lf_phase = LF_AFTER_COLON;
                end else if (i_byte != CH_SPACE) begin
                    // restart the name search at this byte
                    o_state.lf_phase   = LF_SEARCH;
                    o_state.name_match = (w_lc == CH_LO_C) ? 4'd1 : 4'd0;
                end
            end
            LF_AFTER_COLON: begin
                if (w_digit) begin
                    o_state.value    = {7'b0, w_digit_val};
                    o_state.lf_phase = LF_DIGITS;
                end else if (i_byte != CH_SPACE) begin
                    o_state.value    = '0;
                    o_state.lf_phase = LF_FINISHED;
                end
            end
            LF_DIGITS: begin
                if (w_digit) begin
                    o_state.value = (w_value_x10 > {4'b0, LEN_MAX}) ? LEN_MAX
                                                                    : w_value_x10[LEN_W-1:0];
                end else begin
                    o_state.lf_phase = LF_FINISHED;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

>>> hw/rtl/hrf_core.sv
// Framer core: request state registers and per-byte next-state logic.
`timescale 1ns / 1ps

module hrf_core #(
    parameter int BUFFER_BYTES = hrf_pkg::HRF_BUFFER_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  hrf_pkg::t_in  i_item,
    output hrf_pkg::t_out o_result
);
    import hrf_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_BYTES);
    localparam int SUM_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BUFFER_BYTES - 1);

    // State registers
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_phase           r_phase, n_phase;
    logic [2:0]       r_blank, n_blank;
    t_len_state       r_len, n_len;
    logic [CNT_W-1:0] r_hdr, n_hdr;
    t_method          r_method, n_method;

    t_len_state       w_len_parsed;
    logic [CNT_W-1:0] w_cnt_inc;
    logic [2:0]       w_blank_next;
    t_method          w_method_next;
    logic             w_closed;
    logic             w_overflow;
    logic [SUM_W-1:0] w_body_end;
    t_phase           w_phase_mid;

    hrf_len_parse u_len_parse (
        .i_state (r_len),
        .i_byte  (i_item.data_byte),
        .o_state (w_len_parsed)
    );

    assign w_cnt_inc  = r_cnt + CNT_W'(1);
    assign w_closed   = (i_item.kind == KIND_DATA)
                        && (r_phase != PH_WAIT_HEADER) && (r_phase != PH_WAIT_BODY);
    assign w_overflow = (i_item.kind == KIND_DATA) && !w_closed && (r_cnt >= CNT_LAST);

    // Blank line matcher: CR LF CR LF
    always_comb begin
        if (i_item.data_byte == CH_CR) begin
            w_blank_next = (r_blank == 3'd2) ? 3'd3 : 3'd1;
        end else if (i_item.data_byte == CH_LF) begin
            w_blank_next = (r_blank == 3'd1) ? 3'd2 : (r_blank == 3'd3) ? 3'd4 : 3'd0;
        end else begin
            w_blank_next = 3'd0;
        end
    end

    // Method prefix tracker, keyed on byte position
    always_comb begin
        if (r_cnt == CNT_W'(0)) begin
            w_method_next = (i_item.data_byte == CH_UP_G) ? M_G :
                            (i_item.data_byte == CH_UP_P) ? M_P : M_NONE;
        end else if (r_cnt == CNT_W'(1)) begin
            w_method_next = (r_method == M_G && i_item.data_byte == CH_UP_E) ? M_GE :
                            (r_method == M_P && i_item.data_byte == CH_UP_O) ? M_PO : M_NONE;
        end else if (r_cnt == CNT_W'(2)) begin
            w_method_next = (r_method == M_GE && i_item.data_byte == CH_UP_T) ? M_GET :
                            (r_method == M_PO && i_item.data_byte == CH_UP_S) ? M_POS : M_NONE;
        end else if (r_cnt == CNT_W'(3)) begin
            w_method_next = (r_method == M_GET) ? M_GET :
                            (r_method == M_POS && i_item.data_byte == CH_UP_T) ? M_POST
                                                                                : M_NONE;
        end else begin
            w_method_next = r_method;
        end
    end

    // Next state
    always_comb begin
        n_cnt       = r_cnt;
        n_phase     = r_phase;
        n_blank     = r_blank;
        n_len       = r_len;
        n_hdr       = r_hdr;
        n_method    = r_method;
        w_phase_mid = r_phase;
        w_body_end  = '0;
        if (i_item.kind == KIND_OPEN) begin
            n_cnt                = '0;
            n_phase              = PH_WAIT_HEADER;
            n_blank              = '0;
            n_len.lf_phase       = LF_SEARCH;
            n_len.name_match     = '0;
            n_len.value          = '0;
            n_hdr                = '0;
            n_method             = M_NONE;
        end else if (w_closed) begin
            n_phase = r_phase;
        end else if (w_overflow) begin
            n_phase = PH_OVERFLOW;
        end else begin
            n_cnt    = w_cnt_inc;
            n_method = w_method_next;
            if (r_phase == PH_WAIT_HEADER) begin
                n_len   = w_len_parsed;
                n_blank = w_blank_next;
                if (w_blank_next == 3'd4) begin
                    n_hdr = w_cnt_inc;
                    if (w_len_parsed.lf_phase != LF_DIGITS
                        && w_len_parsed.lf_phase != LF_FINISHED) begin
                        n_len.value = '0;
                    end
                    w_phase_mid = (n_len.value != '0) ? PH_WAIT_BODY : PH_DONE;
                end
            end
            w_body_end = SUM_W'(n_hdr) + SUM_W'(n_len.value);
            if (w_phase_mid == PH_WAIT_BODY && SUM_W'(w_cnt_inc) >= w_body_end) begin
                n_phase = PH_DONE;
            end else begin
                n_phase = w_phase_mid;
            end
        end
    end

    // Result fields
    always_comb begin
        if (i_item.kind == KIND_OPEN) begin
            o_result.status = ST_WAIT_HEADER;
        end else if (w_closed) begin
            o_result.status = ST_CLOSED;
        end else begin
            case (n_phase)
                PH_OVERFLOW:  o_result.status = ST_OVERFLOW;
                PH_WAIT_BODY: o_result.status = ST_WAIT_BODY;
                PH_DONE: begin
                    o_result.status = (n_method == M_GET)  ? ST_DONE_GET  :
                                      (n_method == M_POST) ? ST_DONE_POST : ST_DONE_BAD;
                end
                default:      o_result.status = ST_WAIT_HEADER;
            endcase
        end
        o_result.header_length = HDR_W'(n_hdr);
        o_result.body_length   = (n_hdr != '0) ? n_len.value : '0;
    end

    // State update on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt               <= '0;
            r_phase             <= PH_CLOSED;
            r_blank             <= '0;
            r_len.lf_phase      <= LF_SEARCH;
            r_len.name_match    <= '0;
            r_len.value         <= '0;
            r_hdr               <= '0;
            r_method            <= M_NONE;
        end else if (i_fire) begin
            r_cnt    <= n_cnt;
            r_phase  <= n_phase;
            r_blank  <= n_blank;
            r_len    <= n_len;
            r_hdr    <= n_hdr;
            r_method <= n_method;
        end
    end

endmodule

>>> hw/rtl/http_request_framer_core.sv
// Top level of the HTTP request framer: input register, core and result register.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    i_in_data  (kind, data_byte)
//   result    out        o_out_valid / i_out_stall  o_out_data (status, header_length,
//                                                              body_length)
//
// One transaction a cycle sustained while the result side does not stall; each input
// transaction is captured by the input register when it is accepted, and its result is
// loaded into the result register when it advances from there, which raises o_out_valid.
// The per-byte state update is a single pass through the core between the two.
// Reset (synchronous, active low) leaves the request phase closed and all matchers clear.
// A stall on the result side holds the result register and then the input register;
// o_in_stall rises only when the input register is full and cannot move on.
`timescale 1ns / 1ps

module http_request_framer_core #(
    parameter int BUFFER_BYTES = hrf_pkg::HRF_BUFFER_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  hrf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output hrf_pkg::t_out o_out_data
);
    import hrf_pkg::*;

    logic  r_in_valid;
    t_in   r_in;
    logic  r_out_valid;
    t_out  r_out;
    t_out  w_result;
    logic  w_out_ready;
    logic  w_advance;

    // Pipeline flow control
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_advance   = r_in_valid && w_out_ready;
    assign o_in_stall  = r_in_valid && !w_out_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    hrf_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_item   (r_in),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // A held input transaction is neither lost nor altered
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in)))
        else $error("input register dropped or changed a held transaction");

    // Before the blank line no lengths are reported
    a_wait_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_WAIT_HEADER)
        |-> (o_out_data.header_length == '0 && o_out_data.body_length == '0))
        else $error("lengths reported while waiting for header");

    // Waiting for body needs a header and a nonzero body length
    a_wait_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_WAIT_BODY)
        |-> (o_out_data.header_length != '0 && o_out_data.body_length != '0))
        else $error("waiting for body without header or length");

    // Completion only happens after the header ends
    a_done_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_DONE_GET
                         || o_out_data.status == ST_DONE_POST
                         || o_out_data.status == ST_DONE_BAD))
        |-> (o_out_data.header_length != '0))
        else $error("request done without header length");
`endif

endmodule

>>> tb/sv/http_request_framer_core_test.sv
// Self-checking testbench for the HTTP request framer: directed and random request streams.
`timescale 1ns / 1ps

module http_request_framer_core_test;
    import hrf_pkg::*;

    localparam int MAX_SHOWN    = 10;
    localparam int RANDOM_ITEMS = 370;
    localparam int DRAIN_LIMIT  = 5000;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    http_request_framer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Framer state as the testbench predicts it
    logic [10:0] req_bytes   = '0;
    t_phase      req_phase   = PH_CLOSED;
    logic [2:0]  crlf_seen   = '0;
    logic [3:0]  name_pos    = '0;
    t_lf_phase   cl_phase    = LF_SEARCH;
    logic [10:0] cl_value    = '0;
    logic [9:0]  hdr_bytes   = '0;
    t_method     method_seen = M_NONE;
    string       cl_name     = "content-length";

    t_out        framed_q[$];
    logic [7:0]  pending_bytes[$];
    int          error_count  = 0;
    int          active_items = 0;
    bit          gaps_on      = 1'b1;

    function automatic void clear_request();
        req_bytes   = '0;
        crlf_seen   = '0;
        name_pos    = '0;
        cl_phase    = LF_SEARCH;
        cl_value    = '0;
        hdr_bytes   = '0;
        method_seen = M_NONE;
    endfunction

    // GET / POST prefix over the first four bytes
    function automatic t_method next_method(input int pos, input t_method m,
                                            input logic [7:0] c);
        t_method n;
        n = M_NONE;
        case (pos)
            0: begin
                if (c == CH_UP_G) n = M_G;
                else if (c == CH_UP_P) n = M_P;
            end
            1: begin
                if (m == M_G && c == CH_UP_E) n = M_GE;
                else if (m == M_P && c == CH_UP_O) n = M_PO;
            end
            2: begin
                if (m == M_GE && c == CH_UP_T) n = M_GET;
                else if (m == M_PO && c == CH_UP_S) n = M_POS;
            end
            3: begin
                if (m == M_GET) n = M_GET;
                else if (m == M_POS && c == CH_UP_T) n = M_POST;
            end
            default: n = m;
        endcase
        return n;
    endfunction

    function automatic void step_name(input logic [7:0] lc);
        if (name_pos < NAME_LEN && lc == cl_name[name_pos]) begin
            name_pos = name_pos + 1'b1;
            if (name_pos == NAME_LEN) begin
                name_pos = '0;
                cl_phase = LF_BEFORE_COLON;
            end
        end else begin
            name_pos = (lc == CH_LO_C) ? 4'd1 : 4'd0;
        end
    endfunction

    // content-length name, spaces, colon, spaces, digits
    function automatic void scan_length_field(input logic [7:0] c, input logic [7:0] lc);
        logic is_digit;
        int   v;
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        case (cl_phase)
            LF_SEARCH: step_name(lc);
            LF_BEFORE_COLON: begin
                if (c == CH_COLON) begin
                    cl_phase = LF_AFTER_COLON;
                end else if (c != CH_SPACE) begin
                    cl_phase = LF_SEARCH;
                    name_pos = '0;
                    step_name(lc);
                end
            end
            LF_AFTER_COLON: begin
                if (is_digit) begin
                    cl_value = 11'(c - CH_ZERO);
                    cl_phase = LF_DIGITS;
                end else if (c != CH_SPACE) begin
                    cl_value = '0;
                    cl_phase = LF_FINISHED;
                end
            end
            LF_DIGITS: begin
                if (is_digit) begin
                    v = int'(cl_value) * 10 + int'(c - CH_ZERO);
                    cl_value = (v > int'(LEN_MAX)) ? LEN_MAX : 11'(v);
                end else begin
                    cl_phase = LF_FINISHED;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic blank_line_ends(input logic [7:0] c);
        if (c == CH_CR) crlf_seen = (crlf_seen == 3'd2) ? 3'd3 : 3'd1;
        else if (c == CH_LF) crlf_seen = (crlf_seen == 3'd1) ? 3'd2 :
                                         (crlf_seen == 3'd3) ? 3'd4 : 3'd0;
        else crlf_seen = 3'd0;
        return crlf_seen == 3'd4;
    endfunction

    // Advance the predicted framer by one transaction and return its result
    function automatic t_out frame_transaction(input t_in item);
        t_out       r;
        t_status    st;
        logic [7:0] c;
        logic [7:0] lc;
        c  = item.data_byte;
        lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'h20 : c;
        if (item.kind == KIND_OPEN) begin
            clear_request();
            req_phase = PH_WAIT_HEADER;
            st = ST_WAIT_HEADER;
        end else if (req_phase != PH_WAIT_HEADER && req_phase != PH_WAIT_BODY) begin
            st = ST_CLOSED;
        end else if (int'(req_bytes) + 1 >= HRF_BUFFER_BYTES) begin
            req_phase = PH_OVERFLOW;
            st = ST_OVERFLOW;
        end else begin
            method_seen = next_method(int'(req_bytes), method_seen, c);
            req_bytes = req_bytes + 1'b1;
            if (req_phase == PH_WAIT_HEADER) begin
                scan_length_field(c, lc);
                if (blank_line_ends(c)) begin
                    hdr_bytes = req_bytes[9:0];
                    if (cl_phase != LF_DIGITS && cl_phase != LF_FINISHED) cl_value = '0;
                    req_phase = (cl_value != '0) ? PH_WAIT_BODY : PH_DONE;
                end
            end
            if (req_phase == PH_WAIT_BODY &&
                int'(req_bytes) >= int'(hdr_bytes) + int'(cl_value)) begin
                req_phase = PH_DONE;
            end
            if (req_phase == PH_DONE) begin
                if (method_seen == M_GET) st = ST_DONE_GET;
                else if (method_seen == M_POST) st = ST_DONE_POST;
                else st = ST_DONE_BAD;
            end else begin
                st = (req_phase == PH_WAIT_BODY) ? ST_WAIT_BODY : ST_WAIT_HEADER;
            end
        end
        r.status        = st;
        r.header_length = hdr_bytes;
        r.body_length   = (hdr_bytes != '0) ? cl_value : '0;
        return r;
    endfunction

    function automatic void report_error(input string msg);
        error_count++;
        if (error_count <= MAX_SHOWN) $display("mismatch: %s", msg);
    endfunction

    // Send one transaction, with an optional idle burst in front of it
    task automatic send_item(input logic kind, input logic [7:0] value);
        t_in  item;
        t_out r;
        item.kind      = kind;
        item.data_byte = value;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (in_stall);
        r = frame_transaction(item);
        framed_q.push_back(r);
        if (t_status'(r.status) != ST_CLOSED) active_items++;
    endtask

    task automatic send_open();
        send_item(KIND_OPEN, 8'($urandom_range(0, 255)));
    endtask

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
    endfunction

    function automatic void queue_crlf();
        pending_bytes.push_back(CH_CR);
        pending_bytes.push_back(CH_LF);
    endfunction

    // Header name with each letter in random case
    function automatic void queue_length_name();
        logic [7:0] ch;
        for (int i = 0; i < cl_name.len(); i++) begin
            ch = cl_name[i];
            if (ch >= 8'h61 && ch <= 8'h7a && $urandom_range(0, 1) == 1) ch = ch - 8'h20;
            pending_bytes.push_back(ch);
        end
    endfunction

    task automatic send_pending();
        while (pending_bytes.size() != 0) send_item(KIND_DATA, pending_bytes.pop_front());
    endtask

    // Closed phase, method decoding, zero bytes and data after close
    task automatic test_methods();
        send_item(KIND_DATA, 8'h47);
        send_open();
        queue_text("POST");
        queue_crlf();
        queue_crlf();
        send_pending();
        send_item(KIND_DATA, 8'hff);
        send_open();
        pending_bytes.push_back(CH_UP_G);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hff);
        queue_crlf();
        queue_crlf();
        queue_text("GET");
        queue_crlf();
        queue_crlf();
        send_pending();
        send_open();
        queue_text("GET");
        queue_crlf();
        queue_crlf();
        send_pending();
    endtask

    // Name without colon, colon without digits, later occurrences ignored
    task automatic test_length_field_cases();
        send_open();
        queue_text("GET");
        queue_crlf();
        queue_text("content-length content-length: 2");
        queue_crlf();
        queue_crlf();
        queue_text("ab");
        send_pending();
        send_open();
        queue_text("POST");
        queue_crlf();
        queue_text("content-length:");
        queue_crlf();
        queue_crlf();
        send_pending();
        send_open();
        queue_text("GET");
        queue_crlf();
        queue_text("CONTENT-LENGTH : 1");
        queue_crlf();
        queue_text("content-length: 5");
        queue_crlf();
        queue_crlf();
        queue_text("zz");
        send_pending();
    endtask

    // Saturated length, then only part of the body
    task automatic test_saturated_length();
        send_open();
        queue_text("POST /");
        queue_crlf();
        queue_text("Content-Length: 99999");
        queue_crlf();
        queue_crlf();
        send_pending();
        repeat (16) send_item(KIND_DATA, 8'($urandom_range(0, 255)));
        send_item(KIND_DATA, CH_CR);
    endtask

    // One well-formed request with random content, sometimes cut short or overrun
    task automatic send_random_request();
        int mode;
        int remaining;
        send_open();
        case ($urandom_range(0, 5))
            0, 1:    queue_text("GET /");
            2, 3:    queue_text("POST /");
            4:       queue_text("get /");
            default: queue_text("POS /");
        endcase
        if ($urandom_range(0, 1) == 1) begin
            queue_crlf();
            queue_text("H:");
            repeat ($urandom_range(0, 4)) pending_bytes.push_back(8'($urandom_range(33, 126)));
        end
        queue_crlf();
        mode = $urandom_range(0, 9);
        if (mode != 0) begin
            queue_length_name();
            repeat ($urandom_range(0, 2)) pending_bytes.push_back(CH_SPACE);
            case (mode)
                1: begin
                    queue_text("x");
                    queue_length_name();
                    queue_text(":7");
                end
                2: queue_text(": x");
                3: queue_text(":99999");
                default: begin
                    pending_bytes.push_back(CH_COLON);
                    repeat ($urandom_range(0, 2)) pending_bytes.push_back(CH_SPACE);
                    if ($urandom_range(0, 3) == 0) pending_bytes.push_back(CH_ZERO);
                    queue_text($sformatf("%0d", $urandom_range(0, 20)));
                    if ($urandom_range(0, 3) == 0) begin
                        queue_crlf();
                        queue_length_name();
                        queue_text(": 9");
                    end
                end
            endcase
            queue_crlf();
        end
        queue_crlf();
        send_pending();
        // body: mostly complete, sometimes truncated before a reopen
        if (req_phase == PH_WAIT_BODY) begin
            remaining = int'(hdr_bytes) + int'(cl_value) - int'(req_bytes);
            if (remaining > 24) remaining = $urandom_range(0, 24);
            else if ($urandom_range(0, 9) == 0) remaining = $urandom_range(0, remaining - 1);
            repeat (remaining) send_item(KIND_DATA, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) send_item(KIND_DATA, 8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly well-formed requests, some raw noise; no idling near the end
    task automatic test_random_traffic(input int target);
        int start_count;
        start_count = active_items;
        while (active_items - start_count < target) begin
            gaps_on = (active_items - start_count < target - 80);
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(5, 15)) begin
                    if ($urandom_range(0, 11) == 0) send_open();
                    else send_item(KIND_DATA, 8'($urandom_range(0, 255)));
                end
            end else begin
                send_random_request();
            end
        end
    endtask

    // Receiver stall bursts
    initial begin
        forever begin
            if (gaps_on && $urandom_range(0, 2) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (framed_q.size() == 0) begin
                report_error($sformatf("unexpected result status %0d hdr %0d body %0d",
                             out_data.status, out_data.header_length, out_data.body_length));
            end else begin
                want = framed_q.pop_front();
                if (out_data.status !== want.status ||
                    out_data.header_length !== want.header_length ||
                    out_data.body_length !== want.body_length) begin
                    report_error($sformatf(
                        "expected status %0d hdr %0d body %0d, got status %0d hdr %0d body %0d",
                        want.status, want.header_length, want.body_length,
                        out_data.status, out_data.header_length, out_data.body_length));
                end
            end
        end
    end

    initial begin
        int wait_cycles;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_methods();
        test_length_field_cases();
        test_saturated_length();
        test_random_traffic(RANDOM_ITEMS);
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (framed_q.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && framed_q.size() == 0) begin
            $display("[http_request_framer_core] OK");
        end else begin
            $display("[http_request_framer_core] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("[http_request_framer_core] ERROR");
        $finish;
    end

endmodule
